// ===== rtl/core/kabe_pkg.sv =====
package kabe_pkg;

    localparam int DATA_W  = 32;
    localparam int DT_W    = 16;
    localparam int NOISE_W = 31;
    localparam int IN_W    = 80;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;
    localparam int MA_W    = 36;
    localparam int MB_W    = 33;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int WIDE_W  = PROD_W + 1;
    localparam int DIV_STEPS = 31;
    localparam int DCNT_W  = 5;

    localparam logic [NOISE_W-1:0] APN_RESET = 31'd1073742;
    localparam logic [NOISE_W-1:0] BPN_RESET = 31'd3221225;
    localparam logic [NOISE_W-1:0] MN_RESET  = 31'd32212255;

    localparam logic [CIDX_W-1:0] CFG_APN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BPN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MN  = 2'd2;

    typedef enum logic [3:0] {
        OP_RATE  = 4'd0,
        OP_TPRED = 4'd1,
        OP_P00   = 4'd2,
        OP_P11   = 4'd3,
        OP_ANG   = 4'd4,
        OP_BIAS  = 4'd5,
        OP_AA    = 4'd6,
        OP_AB    = 4'd7,
        OP_BA    = 4'd8,
        OP_BB    = 4'd9
    } op_t;

    typedef struct packed {
        logic load_in;
        logic mul_go;
        logic wb;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic out_load;
        op_t  op;
    } cmd_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_W'(64'sh7FFF_FFFF))
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -WIDE_W'(64'sh8000_0000))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/kabe_ctrl.sv =====
module kabe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_busy,
    output kabe_pkg::cmd_t cmd
);
    import kabe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_WB    = 7'b0000100,
        S_DINIT = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_DFIN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_RATE;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (op_reg == OP_P11)
                begin
                    state_next = S_DINIT;
                end
                else if (op_reg == OP_BB)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 4'd1);
                    state_next = S_MUL;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DFIN;
                end
                else
                begin
                    cnt_next = cnt_reg + DCNT_W'(1);
                end
            end
            S_DFIN:
            begin
                cmd.div_fin = 1'b1;
                op_next     = OP_ANG;
                state_next  = S_MUL;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_RATE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL && op_reg == OP_RATE))
        else $error("accepted item did not start the sequence");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == DCNT_W'(DIV_STEPS - 1)) |=> (state_reg == S_DFIN))
        else $error("divider step count overran");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_busy) |=> (state_reg == S_OUT))
        else $error("result dropped while output stalled");
`endif

endmodule

// ===== rtl/core/kabe_datapath.sv =====
module kabe_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kabe_pkg::cmd_t              cmd,
    input  logic [kabe_pkg::IN_W-1:0]   in_data,
    input  logic                        cfg_we,
    input  logic [kabe_pkg::CIDX_W-1:0] cfg_idx,
    input  logic [kabe_pkg::CDATA_W-1:0] cfg_wdata,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [kabe_pkg::DATA_W-1:0] out_data,
    output logic                        out_busy
);
    import kabe_pkg::*;

    logic [NOISE_W-1:0] apn_reg, bpn_reg, mn_reg;

    logic signed [DATA_W-1:0] angle_reg, bias_reg;
    logic signed [DATA_W-1:0] aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [DATA_W-1:0] meas_reg, rate_reg, y_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [MA_W-1:0]   inner_reg;
    logic signed [DATA_W-1:0] k0_reg, k1_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [DATA_W:0]  dsor_reg;
    logic [DATA_W+1:0] rem0_reg, rem1_reg;
    logic [DIV_STEPS-1:0] dvd0_reg, dvd1_reg, q0_reg, q1_reg;
    logic neg0_reg, neg1_reg, sat0_reg, sat1_reg, zero_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;

    logic signed [MA_W-1:0]   opa;
    logic signed [MB_W-1:0]   opb;
    logic signed [PROD_W-1:0] r16, r30;
    logic signed [MB_W-1:0]   t_val;
    logic signed [DATA_W-1:0] meas_in, gyro_in;

    logic signed [DATA_W+1:0] s_val;
    logic [DATA_W:0]          mag_s;
    logic [DATA_W:0]          mag_n0, mag_n1;
    logic [DATA_W+1:0]        trial0, trial1;
    logic signed [DATA_W-1:0] k0_fin, k1_fin;

    assign meas_in = in_data[DATA_W-1:0];
    assign gyro_in = in_data[2*DATA_W-1:DATA_W];

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.op)
            OP_RATE:  begin opa = MA_W'(rate_reg);  opb = MB_W'({1'b0, dt_reg}); end
            OP_TPRED: begin opa = MA_W'(bb_reg);    opb = MB_W'({1'b0, dt_reg}); end
            OP_P00:   begin opa = inner_reg;        opb = MB_W'({1'b0, dt_reg}); end
            OP_P11:   begin opa = MA_W'({1'b0, bpn_reg}); opb = MB_W'({1'b0, dt_reg}); end
            OP_ANG:   begin opa = MA_W'(k0_reg);    opb = MB_W'(y_reg);   end
            OP_BIAS:  begin opa = MA_W'(k1_reg);    opb = MB_W'(y_reg);   end
            OP_AA:    begin opa = MA_W'(k0_reg);    opb = MB_W'(p00_reg); end
            OP_AB:    begin opa = MA_W'(k0_reg);    opb = MB_W'(p01_reg); end
            OP_BA:    begin opa = MA_W'(k1_reg);    opb = MB_W'(p00_reg); end
            OP_BB:    begin opa = MA_W'(k1_reg);    opb = MB_W'(p01_reg); end
            default:  begin opa = '0;               opb = '0;             end
        endcase
    end

    assign r16   = (prod_reg + PROD_W'(1 << 15)) >>> 16;
    assign r30   = (prod_reg + PROD_W'(1 << 29)) >>> 30;
    assign t_val = r16[MB_W-1:0];

    assign s_val  = (DATA_W+2)'(p00_reg) + (DATA_W+2)'({1'b0, mn_reg});
    assign mag_s  = s_val[DATA_W+1] ? (DATA_W+1)'(-s_val) : s_val[DATA_W:0];
    assign mag_n0 = p00_reg[DATA_W-1] ? -(DATA_W+1)'(p00_reg) : (DATA_W+1)'(p00_reg);
    assign mag_n1 = p10_reg[DATA_W-1] ? -(DATA_W+1)'(p10_reg) : (DATA_W+1)'(p10_reg);
    assign trial0 = {rem0_reg[DATA_W:0], dvd0_reg[DIV_STEPS-1]};
    assign trial1 = {rem1_reg[DATA_W:0], dvd1_reg[DIV_STEPS-1]};

    always_comb
    begin
        if (zero_reg)
        begin
            k0_fin = '0;
        end
        else if (sat0_reg)
        begin
            k0_fin = neg0_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            k0_fin = neg0_reg ? -$signed({1'b0, q0_reg}) : $signed({1'b0, q0_reg});
        end
        if (zero_reg)
        begin
            k1_fin = '0;
        end
        else if (sat1_reg)
        begin
            k1_fin = neg1_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            k1_fin = neg1_reg ? -$signed({1'b0, q1_reg}) : $signed({1'b0, q1_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apn_reg   <= APN_RESET;
            bpn_reg   <= BPN_RESET;
            mn_reg    <= MN_RESET;
            angle_reg <= '0;
            bias_reg  <= '0;
            aa_reg    <= '0;
            ab_reg    <= '0;
            ba_reg    <= '0;
            bb_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_APN)
                begin
                    apn_reg <= cfg_wdata[NOISE_W-1:0];
                end
                else if (cfg_idx == CFG_BPN)
                begin
                    bpn_reg <= cfg_wdata[NOISE_W-1:0];
                end
                else if (cfg_idx == CFG_MN)
                begin
                    mn_reg <= cfg_wdata[NOISE_W-1:0];
                end
            end
            if (cmd.wb)
            begin
                unique case (cmd.op)
                    OP_RATE: angle_reg <= sat32(WIDE_W'(angle_reg) + WIDE_W'(r16));
                    OP_ANG:  angle_reg <= sat32(WIDE_W'(angle_reg) + WIDE_W'(r30));
                    OP_BIAS: bias_reg  <= sat32(WIDE_W'(bias_reg) + WIDE_W'(r30));
                    OP_AA:   aa_reg    <= sat32(WIDE_W'(p00_reg) - WIDE_W'(r30));
                    OP_AB:   ab_reg    <= sat32(WIDE_W'(p01_reg) - WIDE_W'(r30));
                    OP_BA:   ba_reg    <= sat32(WIDE_W'(p10_reg) - WIDE_W'(r30));
                    OP_BB:   bb_reg    <= sat32(WIDE_W'(p11_reg) - WIDE_W'(r30));
                    default: ;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            meas_reg <= meas_in;
            dt_reg   <= in_data[2*DATA_W+DT_W-1:2*DATA_W];
            rate_reg <= sat32(WIDE_W'(gyro_in) - WIDE_W'(bias_reg));
        end
        if (cmd.mul_go)
        begin
            prod_reg <= opa * opb;
        end
        if (cmd.wb)
        begin
            unique case (cmd.op)
                OP_TPRED:
                begin
                    inner_reg <= MA_W'(t_val) - MA_W'(ab_reg) - MA_W'(ba_reg)
                                 + MA_W'({1'b0, apn_reg});
                    p01_reg   <= sat32(WIDE_W'(ab_reg) - WIDE_W'(t_val));
                    p10_reg   <= sat32(WIDE_W'(ba_reg) - WIDE_W'(t_val));
                end
                OP_P00:  p00_reg <= sat32(WIDE_W'(aa_reg) + WIDE_W'(r16));
                OP_P11:  p11_reg <= sat32(WIDE_W'(bb_reg) + WIDE_W'(r16));
                default: ;
            endcase
        end
        if (cmd.div_init)
        begin
            dsor_reg <= mag_s;
            zero_reg <= (s_val == '0);
            neg0_reg <= p00_reg[DATA_W-1] ^ s_val[DATA_W+1];
            neg1_reg <= p10_reg[DATA_W-1] ^ s_val[DATA_W+1];
            sat0_reg <= ({1'b0, mag_n0} >= {mag_s, 1'b0});
            sat1_reg <= ({1'b0, mag_n1} >= {mag_s, 1'b0});
            rem0_reg <= (DATA_W+2)'(mag_n0 >> 1);
            rem1_reg <= (DATA_W+2)'(mag_n1 >> 1);
            dvd0_reg <= {mag_n0[0], (DIV_STEPS-1)'(0)};
            dvd1_reg <= {mag_n1[0], (DIV_STEPS-1)'(0)};
            q0_reg   <= '0;
            q1_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            dvd0_reg <= dvd0_reg << 1;
            dvd1_reg <= dvd1_reg << 1;
            if (trial0 >= {1'b0, dsor_reg})
            begin
                rem0_reg <= trial0 - {1'b0, dsor_reg};
                q0_reg   <= {q0_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem0_reg <= trial0;
                q0_reg   <= {q0_reg[DIV_STEPS-2:0], 1'b0};
            end
            if (trial1 >= {1'b0, dsor_reg})
            begin
                rem1_reg <= trial1 - {1'b0, dsor_reg};
                q1_reg   <= {q1_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem1_reg <= trial1;
                q1_reg   <= {q1_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.div_fin)
        begin
            k0_reg <= k0_fin;
            k1_reg <= k1_fin;
            y_reg  <= sat32(WIDE_W'(meas_reg) - WIDE_W'(angle_reg));
        end
        if (cmd.out_load)
        begin
            out_data_reg <= angle_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_busy  = out_valid_reg && !out_ready;

`ifndef ASSERT_OFF
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("result appeared without a load");
    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_fin && zero_reg) |=> (k0_reg == '0 && k1_reg == '0))
        else $error("zero innovation variance gave a nonzero gain");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) && !zero_reg && !sat0_reg |-> (rem0_reg < {1'b0, dsor_reg}))
        else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/core/kalman_angle_bias_estimator_top.sv =====
// Two-state angle / gyro-bias Kalman filter.
// Input stream s_axis: one transfer per sample carrying the accelerometer
// angle, gyro rate and time step. Output stream m_axis: one transfer per
// sample carrying the corrected angle. Configuration channel cfg: write the
// angle process noise (index 0), bias process noise (index 1) and
// measurement noise (index 2); other indexes are ignored. Write only while
// no sample is in flight.
// Each sample runs ten products on one shared multiplier (each a multiply
// then a write-back) and both gain divisions together on a radix-2 divider
// of 31 steps. The result is loaded into the output register at the end of
// that sequence, and a new sample is accepted only after the previous one's
// result has been loaded there.
// A finished result waits in the output register; if m_axis_tready stays
// low the next sample is still accepted and computed, and its result holds
// until the waiting one is taken.
// Reset clears the estimates and covariance to zero and loads the noise
// registers with their defaults; no clearing pass follows.
module kalman_angle_bias_estimator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // measured_angle, gyro_rate, time_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // estimated_angle
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data        // noise value in bits 30:0
);
    import kabe_pkg::*;

    cmd_t cmd;
    logic out_busy;

    assign cfg_ready = 1'b1;

    kabe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (out_busy),
        .cmd      (cmd)
    );

    kabe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_busy  (out_busy)
    );

endmodule
